>>> hw/rtl/utf8_to_ucs2_decoder_assert.svh
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder assertion macros
// Shared property forms for the decoder's port checker. Each macro expects
// clk and rst_n to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UCS2_DECODER_ASSERT_SVH
`define UTF8_TO_UCS2_DECODER_ASSERT_SVH

// same-cycle implication
`define U8U2_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u8u2 implication failed");

// next-cycle implication
`define U8U2_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u8u2 next-cycle implication failed");

`endif

>>> hw/rtl/u8u2_pkg.sv
// ----------------------------------------------------------------------------
// u8u2_pkg
// Shared types and constants for the UTF-8 to UCS-2 decoder.
// ----------------------------------------------------------------------------
package u8u2_pkg;

    localparam int unsigned MAX_COUNT_DEFAULT = 255;
    localparam int unsigned COUNT_W           = 8;
    localparam int unsigned UNIT_W            = 16;
    localparam int unsigned PART_W            = 12;

    // byte class masks and patterns
    localparam logic [7:0] MASK_TOP3   = 8'hE0;
    localparam logic [7:0] MASK_TOP2   = 8'hC0;
    localparam logic [7:0] MASK_TOP1   = 8'h80;
    localparam logic [7:0] MASK_TOP4   = 8'hF0;
    localparam logic [7:0] MASK_CONT   = 8'h3F;
    localparam logic [7:0] MASK_LEAD2  = 8'h1F;
    localparam logic [7:0] MASK_LEAD3  = 8'h0F;
    localparam logic [7:0] PAT_LEAD2   = 8'hC0;
    localparam logic [7:0] PAT_CONT    = 8'h80;
    localparam logic [7:0] PAT_LEAD3   = 8'hE0;

    typedef struct packed {
        logic [UNIT_W-1:0]  code_unit;
        logic               is_end;
        logic               is_error;
        logic [COUNT_W-1:0] unit_count;
    } result_t;

    // pipeline flow control between stages
    typedef struct packed {
        logic valid;
        logic advance;
    } flow_t;

endpackage

>>> hw/rtl/u8u2_in_reg.sv
// ----------------------------------------------------------------------------
// u8u2_in_reg
// Input register: holds one byte item until the decode stage consumes it.
// ----------------------------------------------------------------------------
module u8u2_in_reg (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       advance,
    output logic       byte_valid,
    output logic [7:0] byte_q
);
    import u8u2_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // free when empty or draining this cycle
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_q     = byte_reg;

endmodule

>>> hw/rtl/u8u2_decode.sv
// ----------------------------------------------------------------------------
// u8u2_decode
// Decode state machine: tracks sequence position, assembles payload bits
// and counts units; produces at most one result per consumed byte.
// ----------------------------------------------------------------------------
module u8u2_decode #(
    parameter int unsigned MAX_COUNT = u8u2_pkg::MAX_COUNT_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  u8u2_pkg::flow_t   flow,
    input  logic [7:0]        byte_q,
    output logic              res_valid,
    output u8u2_pkg::result_t res
);
    import u8u2_pkg::*;

    typedef enum logic [1:0] {
        MODE_LEAD = 2'd0,
        MODE_LAST = 2'd1,
        MODE_MID  = 2'd2,
        MODE_DROP = 2'd3
    } mode_t;

    localparam logic [COUNT_W-1:0] COUNT_CAP =
        (MAX_COUNT > 255) ? COUNT_W'(255) : COUNT_W'(MAX_COUNT);

    mode_t              mode_reg,    mode_next;
    logic [PART_W-1:0]  partial_reg, partial_next;
    logic [COUNT_W-1:0] units_reg,   units_next;
    logic               is_cont;
    logic               is_nul;
    logic [COUNT_W-1:0] units_inc;

    assign is_cont   = (byte_q & MASK_TOP2) == PAT_CONT;
    assign is_nul    = byte_q == 8'd0;
    assign units_inc = (units_reg < COUNT_CAP) ? units_reg + 1'b1 : units_reg;

    // next state and result for the byte in the input register
    always_comb
    begin
        mode_next    = mode_reg;
        partial_next = partial_reg;
        units_next   = units_reg;
        res_valid    = 1'b0;
        res          = '0;
        case (mode_reg)
            MODE_LEAD:
            begin
                if (is_nul)
                begin
                    res_valid        = 1'b1;
                    res.is_end       = 1'b1;
                    res.unit_count   = units_reg;
                    units_next       = '0;
                    partial_next     = '0;
                end
                else if ((byte_q & MASK_TOP1) == 8'd0)
                begin
                    res_valid        = 1'b1;
                    res.code_unit    = {8'd0, byte_q};
                    res.unit_count   = units_inc;
                    units_next       = units_inc;
                    partial_next     = '0;
                end
                else if ((byte_q & MASK_TOP3) == PAT_LEAD2)
                begin
                    partial_next = {4'd0, byte_q & MASK_LEAD2};
                    mode_next    = MODE_LAST;
                end
                else if ((byte_q & MASK_TOP4) == PAT_LEAD3)
                begin
                    partial_next = {4'd0, byte_q & MASK_LEAD3};
                    mode_next    = MODE_MID;
                end
                else
                begin
                    // stray continuation, four-byte lead or other invalid lead byte
                    res_valid      = 1'b1;
                    res.is_end     = 1'b1;
                    res.is_error   = 1'b1;
                    res.unit_count = units_reg;
                    units_next     = '0;
                    partial_next   = '0;
                    mode_next      = MODE_DROP;
                end
            end
            MODE_MID, MODE_LAST:
            begin
                if (!is_cont)
                begin
                    res_valid      = 1'b1;
                    res.is_end     = 1'b1;
                    res.is_error   = 1'b1;
                    res.unit_count = units_reg;
                    units_next     = '0;
                    partial_next   = '0;
                    mode_next      = is_nul ? MODE_LEAD : MODE_DROP;
                end
                else if (mode_reg == MODE_MID)
                begin
                    partial_next = {partial_reg[5:0], byte_q[5:0] & MASK_CONT[5:0]};
                    mode_next    = MODE_LAST;
                end
                else
                begin
                    res_valid      = 1'b1;
                    res.code_unit  = {partial_reg[9:0], byte_q[5:0] & MASK_CONT[5:0]};
                    res.unit_count = units_inc;
                    units_next     = units_inc;
                    partial_next   = '0;
                    mode_next      = MODE_LEAD;
                end
            end
            default:
            begin
                // dropping up to and including the NUL
                if (is_nul)
                begin
                    mode_next = MODE_LEAD;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_LEAD;
            partial_reg <= '0;
            units_reg   <= '0;
        end
        else if (flow.valid && flow.advance)
        begin
            mode_reg    <= mode_next;
            partial_reg <= partial_next;
            units_reg   <= units_next;
        end
    end

endmodule

>>> hw/rtl/u8u2_out_reg.sv
// ----------------------------------------------------------------------------
// u8u2_out_reg
// Result register: holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module u8u2_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  u8u2_pkg::result_t res,
    output logic              free,
    output logic              out_valid,
    input  logic              out_ready,
    output u8u2_pkg::result_t res_q
);
    import u8u2_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    // slot is free when empty or being taken now
    assign free = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign res_q     = res_reg;

endmodule

>>> hw/rtl/utf8_to_ucs2_decoder.sv
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder
// Decodes a NUL-terminated UTF-8 byte stream into UCS-2 code units, with a
// terminator or error item closing each string.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  input    in_valid/in_ready    in_byte
//  output   out_valid/out_ready  code_unit, is_end, is_error, unit_count
//
//  one byte item per cycle when not stalled; bytes pass input then result register
//  throughput is set by the single decode stage between input and result register
//  the result register lets a new byte enter while a finished result waits
//  out_ready low stalls the decode stage only once the result register is full
//  rst_n clears the decode mode, payload bits and unit count asynchronously
// ----------------------------------------------------------------------------
module utf8_to_ucs2_decoder #(
    parameter int unsigned MAX_COUNT = u8u2_pkg::MAX_COUNT_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   in_byte,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [u8u2_pkg::UNIT_W-1:0]  code_unit,
    output logic                         is_end,
    output logic                         is_error,
    output logic [u8u2_pkg::COUNT_W-1:0] unit_count
);
    import u8u2_pkg::*;

    flow_t      flow;
    logic       byte_valid;
    logic       advance;
    logic [7:0] byte_q;
    logic       res_valid;
    logic       out_free;
    result_t    res;
    result_t    res_q;

    // decode stage moves when the result slot can take its output
    assign advance = byte_valid && out_free;
    assign flow    = '{valid: byte_valid, advance: advance};

    u8u2_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_q     (byte_q)
    );

    u8u2_decode #(
        .MAX_COUNT (MAX_COUNT)
    ) u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .flow      (flow),
        .byte_q    (byte_q),
        .res_valid (res_valid),
        .res       (res)
    );

    u8u2_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && res_valid),
        .res       (res),
        .free      (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_q     (res_q)
    );

    assign code_unit  = res_q.code_unit;
    assign is_end     = res_q.is_end;
    assign is_error   = res_q.is_error;
    assign unit_count = res_q.unit_count;

endmodule

>>> hw/rtl/u8u2_checker.sv
// ----------------------------------------------------------------------------
// u8u2_checker
// Port-level checks on the decoder's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "utf8_to_ucs2_decoder_assert.svh"

module u8u2_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] code_unit,
    input logic        is_end,
    input logic        is_error,
    input logic [7:0]  unit_count
);
    logic        stalled;
    logic [25:0] out_payload;

    assign stalled     = out_valid && !out_ready;
    assign out_payload = {code_unit, is_end, is_error, unit_count};

    // a stalled result item holds its payload
    `U8U2_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(out_payload))

    // an error always closes the string
    `U8U2_ASSERT_IMPLY(a_err_ends, out_valid && is_error, is_end)

    // terminator and error items carry no code unit
    `U8U2_ASSERT_IMPLY(a_end_zero, out_valid && is_end, code_unit == 16'd0)

    // a decoded unit always counts itself
    `U8U2_ASSERT_IMPLY(a_unit_count, out_valid && !is_end, unit_count != 8'd0)

endmodule

bind utf8_to_ucs2_decoder u8u2_checker u_u8u2_checker (.*);
